[sv/forward_dct_8x8_defines.svh]
// Assertion macros used by the forward DCT controller.
`ifndef FORWARD_DCT_8X8_DEFINES_SVH
`define FORWARD_DCT_8X8_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define FDCT_ASSERT_IMPL(lbl, clk_i, rst_ni, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FDCT_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/fdct_pkg.sv]
package fdct_pkg;

  localparam int SampleBits = 9;
  localparam int CoefBits   = 24;
  localparam int WideBits   = 36;

  localparam logic signed [15:0] CHalfSqrt2 = 16'sd11585;
  localparam logic signed [15:0] CK1        = 16'sd21407;
  localparam logic signed [15:0] CK2        = 16'sd8867;
  localparam logic signed [15:0] CK3        = 16'sd6270;

  typedef logic signed [WideBits-1:0] wide_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_WAIT,
    ST_CALC,
    ST_WRITE,
    ST_EMIT
  } fdct_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load;      // write input sample at idx
    logic       rd;        // read one element of current vector
    logic       calc;      // run butterfly on held vector
    logic       wr;        // write one element back
    logic       col;       // column pass when set
    logic [2:0] vec;       // row or column number
    logic [2:0] elem;      // element within vector
    logic       emit_rd;   // read element for output
    logic [5:0] idx;       // flat index for load and emit
  } fdct_cmd_t;

  function automatic wide_t mulq14(input logic signed [15:0] c, input wide_t x);
    logic signed [WideBits+15:0] p;
    p = c * x;
    p = p + (WideBits+16)'(8192);
    return wide_t'(p >>> 14);
  endfunction

endpackage

[sv/fdct_ctrl.sv]
`include "forward_dct_8x8_defines.svh"
module fdct_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              emit_free,
  input  logic              out_fire,
  output logic              in_ready,
  output fdct_pkg::fdct_cmd_t cmd
);
  import fdct_pkg::*;

  fdct_state_t state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;   // load count or emit count
  logic [3:0]  vec_r, vec_nxt;   // bit 3 selects column pass
  logic [2:0]  el_r, el_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      vec_r   <= '0;
      el_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      vec_r   <= vec_nxt;
      el_r    <= el_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    vec_nxt   = vec_r;
    el_nxt    = el_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.col   = vec_r[3];
    cmd.vec   = vec_r[2:0];
    cmd.elem  = el_r;
    cmd.idx   = cnt_r;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          cnt_nxt  = cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            state_nxt = ST_READ;
            vec_nxt   = '0;
            el_nxt    = '0;
          end
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        el_nxt = el_r + 3'd1;
        if (el_r == 3'd7) state_nxt = ST_WAIT;
      end
      // last element's read data lands in the vector here
      ST_WAIT: begin
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr = 1'b1;
        el_nxt = el_r + 3'd1;
        if (el_r == 3'd7) begin
          vec_nxt = vec_r + 4'd1;
          if (vec_r == 4'd15) begin
            state_nxt = ST_EMIT;
            cnt_nxt   = '0;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_EMIT: begin
        if (emit_free) begin
          cmd.emit_rd = 1'b1;
          cnt_nxt     = cnt_r + 6'd1;
          if (cnt_r == 6'd63) state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  `FDCT_ASSERT_IMPL(a_ready_load, clk, rst_n, in_ready, state_r == ST_LOAD, "ready outside load")
  `FDCT_ASSERT_NEXT(a_load_done, clk, rst_n, in_fire && cnt_r == 6'd63, state_r == ST_READ,
    "no transform after 64th sample")
  `FDCT_ASSERT_IMPL(a_no_out_load, clk, rst_n, out_fire, state_r != ST_READ,
    "output during butterfly read")
endmodule

[sv/fdct_dp.sv]
module fdct_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fdct_pkg::fdct_cmd_t               cmd,
  input  logic signed [fdct_pkg::SampleBits-1:0] sample,
  input  logic                              out_ready,
  output logic                              emit_free,
  output logic                              out_valid,
  output logic signed [fdct_pkg::CoefBits-1:0] coefficient,
  output logic [5:0]                        coef_index,
  output logic                              last
);
  import fdct_pkg::*;

  wide_t      mem [64];
  wide_t      v_r [8];
  wide_t      rd_q;
  logic       rd_vld_r;
  logic [2:0] rd_el_r;
  logic [5:0] rd_idx_r;
  logic       pend_r;           // emit read data pending
  logic       out_valid_r;
  logic signed [CoefBits-1:0] coef_r;
  logic [5:0] idx_r;
  wide_t      res [8];
  logic [5:0] addr;

  always_comb begin
    if (cmd.load || cmd.emit_rd) addr = cmd.idx;
    else if (cmd.col)            addr = {cmd.elem, cmd.vec};
    else                         addr = {cmd.vec, cmd.elem};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) mem[addr] <= wide_t'(sample) <<< 4;
    else if (cmd.wr) mem[addr] <= v_r[cmd.elem];
    rd_q <= mem[addr];
  end

  // butterfly, one vector per calc cycle
  always_comb begin
    wide_t s0, s1, s2, s3, d0, d1, d2, d3, es0, es1, ed0, ed1, z, u, a, b;
    wide_t t01, t23, zz, r, q;
    s0 = v_r[0] + v_r[7]; s1 = v_r[1] + v_r[6];
    s2 = v_r[2] + v_r[5]; s3 = v_r[3] + v_r[4];
    d0 = v_r[0] - v_r[7]; d1 = v_r[1] - v_r[6];
    d2 = v_r[2] - v_r[5]; d3 = v_r[3] - v_r[4];
    es0 = s0 + s3; es1 = s1 + s2; ed0 = s0 - s3; ed1 = s1 - s2;
    z = mulq14(CHalfSqrt2, ed0 + ed1);
    res[0] = es0 + es1; res[4] = es0 - es1;
    res[2] = ed0 + z;   res[6] = ed0 - z;
    u = mulq14(CHalfSqrt2, d1 + d2);
    a = d0 + u; b = d0 - u;
    t01 = d0 + d1; t23 = d2 + d3;
    zz = mulq14(CK3, t23 - t01);
    r = mulq14(CK1, t01) + zz;
    q = mulq14(CK2, t23) + zz;
    res[1] = a + r; res[7] = a - r;
    res[5] = b + q; res[3] = b - q;
  end

  always_ff @(posedge clk) begin
    rd_el_r  <= cmd.elem;
    rd_idx_r <= cmd.idx;
    if (rd_vld_r) v_r[rd_el_r] <= rd_q;
    else if (cmd.calc) v_r <= res;
  end

  assign emit_free = !pend_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd;
      pend_r   <= cmd.emit_rd;
      if (pend_r) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      idx_r <= rd_idx_r;
      if (rd_q > wide_t'(8388607)) coef_r <= 24'sd8388607;
      else if (rd_q < -wide_t'(8388608)) coef_r <= -24'sd8388608;
      else coef_r <= rd_q[CoefBits-1:0];
    end
  end

  assign out_valid   = out_valid_r;
  assign coefficient = coef_r;
  assign coef_index  = idx_r;
  assign last        = idx_r == 6'd63;
endmodule

[sv/forward_dct_8x8.sv]
// 8x8 forward DCT (AAN butterfly, scale factors left in the output). Send 64
// samples row-major; after the 64th the block runs 16 one-dimensional passes
// (rows then columns) through the single-port block buffer, each making 8
// reads, waiting for the last read to land, running the butterfly and making
// 8 writes, then streams 64 coefficients one buffer read at a time, holding
// while a coefficient waits for out_tready. No input is taken during transform and output.
module forward_dct_8x8 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [8:0] sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [23:0] coefficient, [29:24] coef_index
  output logic        out_tlast
);
  import fdct_pkg::*;

  fdct_cmd_t cmd;
  logic      emit_free;
  logic signed [CoefBits-1:0] coef;
  logic [5:0] cidx;

  fdct_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire  (in_tvalid && in_tready),
    .emit_free(emit_free),
    .out_fire (out_tvalid && out_tready),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  fdct_dp u_dp (
    .clk, .rst_n,
    .cmd        (cmd),
    .sample     (in_tdata[SampleBits-1:0]),
    .out_ready  (out_tready),
    .emit_free  (emit_free),
    .out_valid  (out_tvalid),
    .coefficient(coef),
    .coef_index (cidx),
    .last       (out_tlast)
  );

  assign out_tdata = {2'b00, cidx, coef};
endmodule

[sim/fdct_checker.sv]
module fdct_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          coefs_pending,
  output int          coefs_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [23:0] coef;
    logic [5:0]  idx;
    logic        last;
  } coef_t;

  localparam longint QHalfSqrt2 = 11585;
  localparam longint QK1        = 21407;
  localparam longint QK2        = 8867;
  localparam longint QK3        = 6270;

  coef_t       coef_q[$];
  longint      pixels[64];
  logic [5:0]  pix_cnt;

  // round to nearest, ties up; >>> on 64-bit signed is a floor
  function automatic longint qmul(longint c, longint x);
    return (c * x + 8192) >>> 14;
  endfunction

  task automatic butterfly8(inout longint blk[64], input int base, input int stride);
    longint v[8];
    longint s0, s1, s2, s3, d0, d1, d2, d3, e0, e1, f0, f1, z, u, a, b, t01, t23, r, q;
    for (int i = 0; i < 8; i++) v[i] = blk[base + i * stride];
    s0 = v[0] + v[7]; s1 = v[1] + v[6]; s2 = v[2] + v[5]; s3 = v[3] + v[4];
    d0 = v[0] - v[7]; d1 = v[1] - v[6]; d2 = v[2] - v[5]; d3 = v[3] - v[4];
    e0 = s0 + s3; e1 = s1 + s2; f0 = s0 - s3; f1 = s1 - s2;
    z = qmul(QHalfSqrt2, f0 + f1);
    v[0] = e0 + e1; v[4] = e0 - e1; v[2] = f0 + z; v[6] = f0 - z;
    u = qmul(QHalfSqrt2, d1 + d2);
    a = d0 + u; b = d0 - u;
    t01 = d0 + d1; t23 = d2 + d3;
    z = qmul(QK3, t23 - t01);
    r = qmul(QK1, t01) + z;
    q = qmul(QK2, t23) + z;
    v[1] = a + r; v[7] = a - r; v[5] = b + q; v[3] = b - q;
    for (int i = 0; i < 8; i++) blk[base + i * stride] = v[i];
  endtask

  task automatic transform_block();
    longint blk[64];
    longint c;
    coef_t  e;
    for (int i = 0; i < 64; i++) blk[i] = pixels[i] * 16;
    for (int i = 0; i < 8; i++) butterfly8(blk, i * 8, 1);
    for (int i = 0; i < 8; i++) butterfly8(blk, i, 8);
    for (int i = 0; i < 64; i++) begin
      c = blk[i];
      if (c > 8388607) c = 8388607;
      if (c < -8388608) c = -8388608;
      e.coef = c[23:0];
      e.idx  = i[5:0];
      e.last = (i == 63);
      coef_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    coef_t e;
    int    errs;
    errs = 0;
    if (!rst_n) begin
      pix_cnt <= '0;
      fail_count <= 0;
      coefs_seen <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        pixels[pix_cnt] = longint'($signed(in_tdata[8:0]));
        if (pix_cnt == 6'd63) transform_block();
        pix_cnt <= pix_cnt + 6'd1;
      end
      if (out_tvalid && out_tready) begin
        coefs_seen <= coefs_seen + 1;
        if (coef_q.size() == 0) begin
          $error("coefficient transaction with nothing expected");
          errs++;
        end else begin
          e = coef_q.pop_front();
          if (out_tdata[23:0] !== e.coef) begin
            $error("coefficient: expected %0d, got %0d", $signed(e.coef),
                   $signed(out_tdata[23:0]));
            errs++;
          end
          if (out_tdata[29:24] !== e.idx) begin
            $error("coef_index: expected %0d, got %0d", e.idx, out_tdata[29:24]);
            errs++;
          end
          if (out_tlast !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, out_tlast);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    coefs_pending <= coef_q.size();
  end
endmodule

[sim/tb_forward_dct_8x8.sv]
module tb_forward_dct_8x8;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  int          fail_count;
  int          coefs_pending;
  int          coefs_seen;
  int          quiet_cycles;
  int          blocks_sent;

  localparam int QuietLimit = 20000;

  forward_dct_8x8 dut (.*);

  fdct_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // downstream stall pattern: fresh random wait before each coefficient
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk iff out_tvalid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_pixel(input logic [15:0] word, input bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk iff in_tready);
  endtask

  // kind: 0 all max, 1 all min, 2 checkerboard extremes, 3 random, 4 small noise
  task automatic send_block(input int kind);
    logic [15:0] w;
    bit          no_gaps;
    no_gaps = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < 64; i++) begin
      w = 16'($urandom);  // bits above the sample are don't-care
      case (kind)
        0: w[8:0] = 9'h0ff;
        1: w[8:0] = 9'h100;
        2: w[8:0] = (((i >> 3) ^ i) & 1) ? 9'h0ff : 9'h100;
        3: w[8:0] = 9'($urandom);
        default: w[8:0] = 9'($signed($urandom_range(0, 16)) - 8);
      endcase
      send_pixel(w, no_gaps);
    end
    blocks_sent++;
  endtask

  initial begin
    int waited;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    blocks_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_block(0);
    send_block(1);
    send_block(2);
    send_block(3);
    in_tvalid <= 1'b0;
    waited = 0;
    while ((coefs_pending != 0 || coefs_seen != blocks_sent * 64) && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    $display("Sent %0d blocks (max, min, checkerboard, random), checked %0d coefs",
             blocks_sent, coefs_seen);
    if (fail_count == 0 && coefs_pending == 0 && waited < 100000)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

[files.f]
+incdir+sv
sv/fdct_pkg.sv
sv/fdct_ctrl.sv
sv/fdct_dp.sv
sv/forward_dct_8x8.sv
sim/fdct_checker.sv
sim/tb_forward_dct_8x8.sv
